@@ src/epc_pkg.sv @@
package epc_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * WORD_W;
   localparam int QP_W = PROD_W - FRAC_W;
   localparam int ACC_W = 40;
   localparam int RAW_W = 20;
   localparam int DUTY_W = 16;

   // raw/10000 in Q16.16 is raw*4096/625
   localparam int RAW_SHIFT = 12;
   localparam int Y_DIVISOR = 625;
   localparam int DT_DIVISOR = 1000;
   // (u*10000 + 3794*65536) / (84*65536), with the 65536 folded into the qmul
   localparam int DUTY_DIVISOR = 84;
   localparam int DUTY_SCALE = 10000;
   localparam int DUTY_OFFSET = 3794;
   localparam int DUTY_MAX = (1 << DUTY_W) - 1;

   localparam logic signed [WORD_W-1:0] PLANT_A0 = 32'sd0;
   localparam logic signed [WORD_W-1:0] DRIVE_CENTER = 32'sd0;
   localparam logic signed [WORD_W-1:0] DRIVE_MAX = 32'sd786432;
   localparam logic signed [WORD_W-1:0] DRIVE_MIN = 32'sd0;
   localparam logic signed [WORD_W-1:0] PLANT_GAIN_RESET = 32'sd65536;

   // radix-16 constant divider
   localparam int DIV_DIGIT_W = 4;
   localparam int DIV_DIGITS = ACC_W / DIV_DIGIT_W;
   localparam int DIV_CNT_W = $clog2(DIV_DIGITS);
   localparam int DIV_REM_W = 10;
   localparam int DIV_CAT_W = DIV_REM_W + DIV_DIGIT_W;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET,
      CSR_GAIN_PROP,
      CSR_GAIN_SPEED,
      CSR_GAIN_DIST,
      CSR_BETA_ONE,
      CSR_BETA_TWO,
      CSR_BETA_THREE,
      CSR_PLANT_GAIN
   } csr_index_type;

   localparam int NUM_SRC = 23;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_TARGET,
      SRC_KP,
      SRC_KD,
      SRC_KI,
      SRC_B1,
      SRC_B2,
      SRC_B3,
      SRC_B0,
      SRC_POS,
      SRC_SPEED,
      SRC_DIST,
      SRC_Y,
      SRC_E,
      SRC_DPOS,
      SRC_U,
      SRC_UC,
      SRC_A0,
      SRC_CENTER,
      SRC_OFFSET,
      SRC_SCALE,
      SRC_RAW,
      SRC_QUO
   } src_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_ADD_QP,
      ACC_SUB_QP
   } acc_op_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_DPOS,
      DST_E,
      DST_Y,
      DST_U,
      DST_UC,
      DST_Z1,
      DST_Z2,
      DST_Z3
   } dst_type;

   typedef enum logic [1:0] {
      DIV_Y,
      DIV_DT,
      DIV_DUTY
   } div_sel_type;

   typedef struct packed {
      logic        mul_en;
      src_type     mul_a;
      src_type     mul_b;
      acc_op_type  acc_op;
      src_type     acc_src;
      dst_type     dst;
      logic        div_start;
      div_sel_type div_sel;
      logic        wait_div;
      logic        finish;
   } ctrl_type;

   typedef struct packed {
      logic                    busy;
      logic signed [ACC_W-1:0] quotient;
   } div_status_type;

   localparam int UCODE_DEPTH = 41;
   localparam int PC_W = $clog2(UCODE_DEPTH);

endpackage

@@ src/eso_position_controller_top.sv @@
// Position loop around a third-order extended state observer, all values
// signed Q16.16. Each req beat carries one raw position count; the block
// forms the drive from the old position, speed and disturbance estimates,
// advances the observer by one 1 ms tick, clamps the drive and answers with
// one rsp beat holding the PWM duty count, the clamped drive and the new
// position estimate. A 41-step microprogram runs over one shared 32x32
// multiplier and one accumulator, and five constant divisions (count
// scaling, three dt divisions by 1000, the duty divide) go through a
// radix-16 divider that forms ten quotient digits and then fixes the
// sign; only the first division overlaps other work. One item is in
// flight at a time; the next one is taken the cycle after the result is
// loaded, even while that result still waits in the rsp register. A
// finished item whose result finds the rsp register still full holds the
// block, and so req_stall, until rsp is taken. Registers must be written
// through the csr port only while no item is in progress; the block
// itself does not enforce this.
module eso_position_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [epc_pkg::RAW_W-1:0]         req_position_raw,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [epc_pkg::DUTY_W-1:0]        rsp_duty_count,
   output logic signed [epc_pkg::WORD_W-1:0] rsp_drive_level,
   output logic signed [epc_pkg::WORD_W-1:0] rsp_position_estimate,
   input  logic                              csr_write,
   input  logic [epc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [epc_pkg::WORD_W-1:0]        csr_data
);
   import epc_pkg::*;

   ctrl_type                 ctrl;
   div_status_type           div_status;
   logic                     running;
   logic                     fire_finish;
   logic                     req_accept;
   logic                     out_blocked;
   logic signed [ACC_W-1:0]  dividend;
   logic [DUTY_W-1:0]        duty;
   logic signed [WORD_W-1:0] drive;
   logic signed [WORD_W-1:0] pos_estimate;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]        duty_ff;
   logic signed [WORD_W-1:0] drive_ff;
   logic signed [WORD_W-1:0] pos_ff;

   assign req_stall   = running;
   assign req_accept  = req_valid && !req_stall;
   assign out_blocked = rsp_valid_ff && rsp_stall;

   epc_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .div_busy    (div_status.busy),
      .out_blocked (out_blocked),
      .ctrl        (ctrl),
      .running     (running),
      .fire_finish (fire_finish)
   );

   epc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .sel      (ctrl.div_sel),
      .dividend (dividend),
      .status   (div_status)
   );

   epc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .load_raw     (req_accept),
      .raw          (req_position_raw),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .quotient     (div_status.quotient),
      .dividend     (dividend),
      .duty         (duty),
      .drive        (drive),
      .pos_estimate (pos_estimate)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire_finish) begin
         duty_ff  <= duty;
         drive_ff <= drive;
         pos_ff   <= pos_estimate;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_duty_count        = duty_ff;
   assign rsp_drive_level       = drive_ff;
   assign rsp_position_estimate = pos_ff;

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> running)
      else $error("accepted beat did not start the sequencer");

   a_div_not_busy : assert property (@(posedge clock) disable iff (reset)
      ctrl.div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_finish_div_done : assert property (@(posedge clock) disable iff (reset)
      fire_finish |-> (!div_status.busy && !out_blocked))
      else $error("result issued with divider busy or rsp register full");

   a_drive_clamped : assert property (@(posedge clock) disable iff (reset)
      fire_finish |=> (rsp_drive_level <= DRIVE_MAX) && (rsp_drive_level >= DRIVE_MIN))
      else $error("drive outside limits");

endmodule

@@ src/epc_divider.sv @@
module epc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  epc_pkg::div_sel_type             sel,
   input  logic signed [epc_pkg::ACC_W-1:0] dividend,
   output epc_pkg::div_status_type          status
);
   import epc_pkg::*;

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_FIX  = 3'b100
   } dv_state_type;

   dv_state_type            state_ff, state_in;
   div_sel_type             sel_ff, sel_in;
   logic                    neg_ff, neg_in;
   logic [ACC_W-1:0]        mag_ff, mag_in;
   logic [ACC_W-1:0]        qacc_ff, qacc_in;
   logic [DIV_REM_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] quo_ff, quo_in;
   logic [DIV_CAT_W-1:0]    r_cat;
   logic [DIV_DIGIT_W-1:0]  digit;

   function automatic logic [DIV_CAT_W-1:0] div_multiple(input div_sel_type s,
                                                         input logic [DIV_DIGIT_W-1:0] k);
      logic [DIV_CAT_W-1:0] base;
      case (s)
         DIV_Y:    base = DIV_CAT_W'(Y_DIVISOR);
         DIV_DT:   base = DIV_CAT_W'(DT_DIVISOR);
         DIV_DUTY: base = DIV_CAT_W'(DUTY_DIVISOR);
         default:  base = DIV_CAT_W'(DT_DIVISOR);
      endcase
      return DIV_CAT_W'(base * {{(DIV_CAT_W-DIV_DIGIT_W){1'b0}}, k});
   endfunction

   // one quotient digit per cycle: largest k with k*d <= partial remainder
   assign r_cat = {rem_ff, mag_ff[ACC_W-1 -: DIV_DIGIT_W]};

   always_comb begin
      digit = '0;
      for (int k = 1; k < (1 << DIV_DIGIT_W); k++) begin
         if (div_multiple(sel_ff, DIV_DIGIT_W'(k)) <= r_cat) begin
            digit = DIV_DIGIT_W'(k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      qacc_in  = qacc_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               state_in = DV_RUN;
               sel_in   = sel;
               neg_in   = dividend[ACC_W-1];
               mag_in   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
               qacc_in  = '0;
               rem_in   = '0;
               cnt_in   = '0;
            end
         end
         DV_RUN: begin
            mag_in  = mag_ff << DIV_DIGIT_W;
            qacc_in = {qacc_ff[ACC_W-DIV_DIGIT_W-1:0], digit};
            rem_in  = DIV_REM_W'(r_cat - div_multiple(sel_ff, digit));
            cnt_in  = DIV_CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == DIV_CNT_W'(DIV_DIGITS - 1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            // floor for negative dividends: one more step down if inexact
            if (neg_ff) begin
               quo_in = -$signed(qacc_ff) - ((rem_ff != '0) ? ACC_W'(1) : ACC_W'(0));
            end else begin
               quo_in = $signed(qacc_ff);
            end
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sel_ff  <= sel_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      qacc_ff <= qacc_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
   end

   assign status.busy     = (state_ff != DV_IDLE);
   assign status.quotient = quo_ff;

endmodule

@@ src/epc_sequencer.sv @@
module epc_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              div_busy,
   input  logic              out_blocked,
   output epc_pkg::ctrl_type ctrl,
   output logic              running,
   output logic              fire_finish
);
   import epc_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            run_ff, run_in;
   ctrl_type        word;
   ctrl_type        nop_word;

   function automatic ctrl_type uw(input logic mul_en, input src_type mul_a,
                                   input src_type mul_b, input acc_op_type acc_op,
                                   input src_type acc_src, input dst_type dst,
                                   input logic div_start, input div_sel_type div_sel,
                                   input logic wait_div, input logic finish);
      ctrl_type w;
      w.mul_en    = mul_en;
      w.mul_a     = mul_a;
      w.mul_b     = mul_b;
      w.acc_op    = acc_op;
      w.acc_src   = acc_src;
      w.dst       = dst;
      w.div_start = div_start;
      w.div_sel   = div_sel;
      w.wait_div  = wait_div;
      w.finish    = finish;
      return w;
   endfunction

   // microprogram; a product is registered and is ready at the step after its multiply
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      case (pc)
         // y = raw*4096/625, overlapped with the drive sum
         0:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_RAW, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         1:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_POS, DST_NONE,
                    1'b1, DIV_Y, 1'b0, 1'b0);
         2:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_SUB, SRC_TARGET, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         3:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_DPOS,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         4:  w = uw(1'b1, SRC_DPOS, SRC_KP, ACC_LOAD, SRC_CENTER, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         5:  w = uw(1'b1, SRC_KD, SRC_SPEED, ACC_ADD_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         6:  w = uw(1'b1, SRC_DIST, SRC_KI, ACC_ADD_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         7:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_SUB_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         8:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_U,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         9:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_UC,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         10: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_Y, 1'b1, 1'b0);
         11: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_QUO, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         12: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_POS, DST_Y,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         13: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_SUB, SRC_Y, DST_NONE,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         14: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_E,
                    1'b0, DIV_Y, 1'b0, 1'b0);
         // position estimate
         15: w = uw(1'b1, SRC_B1, SRC_E, ACC_LOAD, SRC_SPEED, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         16: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_SUB_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         17: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b1, DIV_DT, 1'b0, 1'b0);
         18: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b1, 1'b0);
         19: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_QUO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         20: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_ADD, SRC_POS, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         21: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_Z1,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         // speed estimate, fed with the new position estimate
         22: w = uw(1'b1, SRC_A0, SRC_POS, ACC_LOAD, SRC_DIST, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         23: w = uw(1'b1, SRC_B2, SRC_E, ACC_ADD_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         24: w = uw(1'b1, SRC_B0, SRC_U, ACC_SUB_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         25: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_ADD_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         26: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b1, DIV_DT, 1'b0, 1'b0);
         27: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b1, 1'b0);
         28: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_QUO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         29: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_ADD, SRC_SPEED, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         // disturbance estimate
         30: w = uw(1'b1, SRC_B3, SRC_E, ACC_LOAD, SRC_ZERO, DST_Z2,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         31: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_SUB_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         32: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b1, DIV_DT, 1'b0, 1'b0);
         33: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DT, 1'b1, 1'b0);
         34: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_LOAD, SRC_QUO, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         35: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_ADD, SRC_DIST, DST_NONE,
                    1'b0, DIV_DT, 1'b0, 1'b0);
         // duty: floor(uc*10000/65536) + 3794, then /84
         36: w = uw(1'b1, SRC_UC, SRC_SCALE, ACC_LOAD, SRC_OFFSET, DST_Z3,
                    1'b0, DIV_DUTY, 1'b0, 1'b0);
         37: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_ADD_QP, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DUTY, 1'b0, 1'b0);
         38: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b1, DIV_DUTY, 1'b0, 1'b0);
         39: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DUTY, 1'b1, 1'b0);
         40: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                    1'b0, DIV_DUTY, 1'b0, 1'b1);
         default: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                         1'b0, DIV_DT, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

   assign nop_word = uw(1'b0, SRC_ZERO, SRC_ZERO, ACC_HOLD, SRC_ZERO, DST_NONE,
                        1'b0, DIV_DT, 1'b0, 1'b0);
   assign word = ucode(pc_ff);

   always_comb begin
      pc_in       = pc_ff;
      run_in      = run_ff;
      fire_finish = 1'b0;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            pc_in  = '0;
         end
      end else if (word.wait_div && div_busy) begin
         pc_in = pc_ff;
      end else if (word.finish) begin
         // hold the last step until the result register is free
         if (!out_blocked) begin
            fire_finish = 1'b1;
            run_in      = 1'b0;
            pc_in       = '0;
         end
      end else begin
         pc_in = PC_W'(pc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         run_ff <= 1'b0;
      end else begin
         pc_ff  <= pc_in;
         run_ff <= run_in;
      end
   end

   assign ctrl    = run_ff ? word : nop_word;
   assign running = run_ff;

endmodule

@@ src/epc_datapath.sv @@
module epc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  epc_pkg::ctrl_type                 ctrl,
   input  logic                              load_raw,
   input  logic [epc_pkg::RAW_W-1:0]         raw,
   input  logic                              csr_write,
   input  logic [epc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [epc_pkg::WORD_W-1:0]        csr_data,
   input  logic signed [epc_pkg::ACC_W-1:0]  quotient,
   output logic signed [epc_pkg::ACC_W-1:0]  dividend,
   output logic [epc_pkg::DUTY_W-1:0]        duty,
   output logic signed [epc_pkg::WORD_W-1:0] drive,
   output logic signed [epc_pkg::WORD_W-1:0] pos_estimate
);
   import epc_pkg::*;

   logic signed [WORD_W-1:0] target_ff, kp_ff, kd_ff, ki_ff;
   logic signed [WORD_W-1:0] b1_ff, b2_ff, b3_ff, b0_ff;
   logic signed [WORD_W-1:0] pos_ff, speed_ff, dist_ff;
   logic signed [WORD_W-1:0] y_ff, e_ff, dpos_ff, u_ff, uc_ff;
   logic [RAW_W-1:0]         raw_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [ACC_W-1:0]  src_vec [NUM_SRC];
   logic signed [WORD_W-1:0] mul_a, mul_b;
   logic signed [WORD_W-1:0] qp;
   logic signed [ACC_W-1:0]  qp_ext;
   logic signed [ACC_W-1:0]  acc_src;
   logic signed [WORD_W-1:0] acc_sat;
   logic signed [WORD_W-1:0] acc_clamp;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [QP_W-1:0] x);
      logic signed [QP_W-1:0] hi;
      logic signed [QP_W-1:0] lo;
      hi = QP_W'({1'b0, {(WORD_W-1){1'b1}}});
      lo = -hi - QP_W'(1);
      if (x > hi) begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end else if (x < lo) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end
      return x[WORD_W-1:0];
   endfunction

   assign src_vec[SRC_ZERO]   = '0;
   assign src_vec[SRC_TARGET] = ACC_W'(target_ff);
   assign src_vec[SRC_KP]     = ACC_W'(kp_ff);
   assign src_vec[SRC_KD]     = ACC_W'(kd_ff);
   assign src_vec[SRC_KI]     = ACC_W'(ki_ff);
   assign src_vec[SRC_B1]     = ACC_W'(b1_ff);
   assign src_vec[SRC_B2]     = ACC_W'(b2_ff);
   assign src_vec[SRC_B3]     = ACC_W'(b3_ff);
   assign src_vec[SRC_B0]     = ACC_W'(b0_ff);
   assign src_vec[SRC_POS]    = ACC_W'(pos_ff);
   assign src_vec[SRC_SPEED]  = ACC_W'(speed_ff);
   assign src_vec[SRC_DIST]   = ACC_W'(dist_ff);
   assign src_vec[SRC_Y]      = ACC_W'(y_ff);
   assign src_vec[SRC_E]      = ACC_W'(e_ff);
   assign src_vec[SRC_DPOS]   = ACC_W'(dpos_ff);
   assign src_vec[SRC_U]      = ACC_W'(u_ff);
   assign src_vec[SRC_UC]     = ACC_W'(uc_ff);
   assign src_vec[SRC_A0]     = ACC_W'(PLANT_A0);
   assign src_vec[SRC_CENTER] = ACC_W'(DRIVE_CENTER);
   assign src_vec[SRC_OFFSET] = ACC_W'(DUTY_OFFSET);
   assign src_vec[SRC_SCALE]  = ACC_W'(DUTY_SCALE);
   assign src_vec[SRC_RAW]    = $signed({{(ACC_W-RAW_W-RAW_SHIFT){1'b0}}, raw_ff,
                                         {RAW_SHIFT{1'b0}}});
   assign src_vec[SRC_QUO]    = quotient;

   assign mul_a   = $signed(src_vec[ctrl.mul_a][WORD_W-1:0]);
   assign mul_b   = $signed(src_vec[ctrl.mul_b][WORD_W-1:0]);
   assign acc_src = src_vec[ctrl.acc_src];

   // Q16.16 product: floor shift, then saturate
   assign qp      = sat_word($signed(prod_ff[PROD_W-1:FRAC_W]));
   assign qp_ext  = ACC_W'(qp);
   assign acc_sat = sat_word(QP_W'(acc_ff));

   always_comb begin
      if (acc_sat > DRIVE_MAX) begin
         acc_clamp = DRIVE_MAX;
      end else if (acc_sat <= DRIVE_MIN) begin
         acc_clamp = DRIVE_MIN;
      end else begin
         acc_clamp = acc_sat;
      end
   end

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD:   acc_in = acc_src;
         ACC_ADD:    acc_in = acc_ff + acc_src;
         ACC_SUB:    acc_in = acc_ff - acc_src;
         ACC_ADD_QP: acc_in = acc_ff + qp_ext;
         ACC_SUB_QP: acc_in = acc_ff - qp_ext;
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         kp_ff     <= '0;
         kd_ff     <= '0;
         ki_ff     <= '0;
         b1_ff     <= '0;
         b2_ff     <= '0;
         b3_ff     <= '0;
         b0_ff     <= PLANT_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET:     target_ff <= $signed(csr_data);
            CSR_GAIN_PROP:  kp_ff     <= $signed(csr_data);
            CSR_GAIN_SPEED: kd_ff     <= $signed(csr_data);
            CSR_GAIN_DIST:  ki_ff     <= $signed(csr_data);
            CSR_BETA_ONE:   b1_ff     <= $signed(csr_data);
            CSR_BETA_TWO:   b2_ff     <= $signed(csr_data);
            CSR_BETA_THREE: b3_ff     <= $signed(csr_data);
            CSR_PLANT_GAIN: b0_ff     <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         speed_ff <= '0;
         dist_ff  <= '0;
      end else begin
         case (ctrl.dst)
            DST_Z1: pos_ff   <= acc_sat;
            DST_Z2: speed_ff <= acc_sat;
            DST_Z3: dist_ff  <= acc_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.dst)
         DST_DPOS: dpos_ff <= acc_sat;
         DST_E:    e_ff    <= acc_sat;
         DST_Y:    y_ff    <= acc_sat;
         DST_U:    u_ff    <= acc_sat;
         DST_UC:   uc_ff   <= acc_clamp;
         default: ;
      endcase
      if (load_raw) begin
         raw_ff <= raw;
      end
      if (ctrl.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      acc_ff <= acc_in;
   end

   assign dividend = acc_ff;

   // acc holds the shifted duty numerator when the last quotient arrives
   always_comb begin
      if (acc_ff <= 0) begin
         duty = '0;
      end else if (quotient > ACC_W'(DUTY_MAX)) begin
         duty = DUTY_W'(DUTY_MAX);
      end else begin
         duty = quotient[DUTY_W-1:0];
      end
   end

   assign drive        = uc_ff;
   assign pos_estimate = pos_ff;

endmodule

@@ sim/tb_eso_position_controller_top.sv @@
`timescale 1ns / 100ps

module tb_eso_position_controller_top;
   import epc_pkg::*;

   typedef logic signed [WORD_W-1:0] q16_type;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      q16_type           drive;
      q16_type           pos;
   } tick_result_type;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -Q_MAX - 1;
   localparam int NUM_CSR = 8;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 150;
   localparam int LONG_HOLD = 600;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RAW_MAX = (1 << RAW_W) - 1;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [RAW_W-1:0]    req_position_raw;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [DUTY_W-1:0]   rsp_duty_count;
   q16_type             rsp_drive_level;
   q16_type             rsp_position_estimate;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]   csr_data;

   eso_position_controller_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_position_raw      (req_position_raw),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_duty_count        (rsp_duty_count),
      .rsp_drive_level       (rsp_drive_level),
      .rsp_position_estimate (rsp_position_estimate),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // observer state and register copy held by the predictor
   q16_type csr_shadow [NUM_CSR];
   q16_type next_set [NUM_CSR];
   q16_type est_pos;
   q16_type est_speed;
   q16_type est_dist;

   tick_result_type pending_ticks [$];

   int mismatches = 0;
   int ticks_sent = 0;
   int ticks_checked = 0;
   int settings_loaded = 0;
   int long_holds_asked = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int walk_pos = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d ticks still pending",
                  cycle_count, pending_ticks.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- fixed-point predictor ----------------

   function automatic longint floor_div(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q -= 1;
      return q;
   endfunction

   function automatic q16_type sat32(longint x);
      if (x > Q_MAX) return q16_type'(Q_MAX);
      if (x < Q_MIN) return q16_type'(Q_MIN);
      return q16_type'(x);
   endfunction

   function automatic q16_type qmul(q16_type a, q16_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat32(floor_div(p, 65536));
   endfunction

   function automatic q16_type tick_advance(q16_type old, longint rate);
      return sat32(longint'(old) + floor_div(rate, DT_DIVISOR));
   endfunction

   task automatic predict_tick(input logic [RAW_W-1:0] raw, output tick_result_type r);
      longint  raw_l;
      longint  y;
      longint  drive_sum;
      longint  n;
      longint  quo;
      q16_type u;
      q16_type err;
      q16_type pos_n;
      q16_type speed_n;
      q16_type dist_n;
      raw_l = longint'(raw);
      y = (raw_l * 65536) / 10000;

      drive_sum = longint'(DRIVE_CENTER)
         + longint'(qmul(sat32(longint'(est_pos) - longint'(csr_shadow[CSR_TARGET])),
                         csr_shadow[CSR_GAIN_PROP]))
         + longint'(qmul(csr_shadow[CSR_GAIN_SPEED], est_speed))
         - longint'(qmul(est_dist, csr_shadow[CSR_GAIN_DIST]));
      u = sat32(drive_sum);

      // observer sees the drive before clamping; speed uses the new position
      err = sat32(longint'(est_pos) - y);
      pos_n = tick_advance(est_pos, longint'(est_speed)
                           - longint'(qmul(csr_shadow[CSR_BETA_ONE], err)));
      speed_n = tick_advance(est_speed, longint'(est_dist)
                             - longint'(qmul(csr_shadow[CSR_BETA_TWO], err))
                             + longint'(qmul(csr_shadow[CSR_PLANT_GAIN], u))
                             + longint'(qmul(PLANT_A0, pos_n)));
      dist_n = tick_advance(est_dist, -longint'(qmul(csr_shadow[CSR_BETA_THREE], err)));
      est_pos = pos_n;
      est_speed = speed_n;
      est_dist = dist_n;

      if (u > DRIVE_MAX) u = DRIVE_MAX;
      else if (u <= DRIVE_MIN) u = DRIVE_MIN;

      n = longint'(u) * DUTY_SCALE + longint'(DUTY_OFFSET) * 65536;
      if (n <= 0) begin
         r.duty = '0;
      end else begin
         quo = n / (longint'(DUTY_DIVISOR) * 65536);
         r.duty = (quo > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : quo[DUTY_W-1:0];
      end
      r.drive = u;
      r.pos = est_pos;
   endtask

   // ---------------- result check ----------------

   always @(posedge clock) begin : check_ticks
      tick_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ticks.size() == 0) begin
            $display("%0t: rsp beat with no tick pending (duty %0d drive %0d pos %0d)",
                     $time, rsp_duty_count, rsp_drive_level, rsp_position_estimate);
            mismatches++;
         end else begin
            want = pending_ticks.pop_front();
            ticks_checked++;
            if (rsp_duty_count !== want.duty) begin
               $display("%0t: duty_count expected %0d, got %0d",
                        $time, want.duty, rsp_duty_count);
               mismatches++;
            end
            if (rsp_drive_level !== want.drive) begin
               $display("%0t: drive_level expected %0d, got %0d",
                        $time, want.drive, rsp_drive_level);
               mismatches++;
            end
            if (rsp_position_estimate !== want.pos) begin
               $display("%0t: position_estimate expected %0d, got %0d",
                        $time, want.pos, rsp_position_estimate);
               mismatches++;
            end
         end
      end
   end

   // receiver: changing stall moods, plus long hold-offs on request
   initial begin : rsp_stall_gen
      int mood;
      int mood_left;
      int hold_left;
      int holds_done;
      mood = 0;
      mood_left = 0;
      hold_left = 0;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done < long_holds_asked) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mood_left == 0) begin
               mood = $urandom_range(0, 3);
               mood_left = $urandom_range(20, 300);
            end
            mood_left--;
            case (mood)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 7) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_tick(input logic [RAW_W-1:0] raw);
      tick_result_type r;
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         burst_left = $urandom_range(1, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_position_raw <= raw;
      do @(posedge clock); while (req_stall);
      predict_tick(raw, r);
      pending_ticks.push_back(r);
      burst_left--;
      ticks_sent++;
   endtask

   task automatic drain_ticks();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings();
      for (int i = 0; i < NUM_CSR; i++) begin
         @(negedge clock);
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= next_set[i];
         csr_shadow[i] = next_set[i];
      end
      @(negedge clock);
      csr_write <= 1'b0;
      settings_loaded++;
   endtask

   function automatic q16_type spread(int span);
      return q16_type'($urandom_range(0, 2 * span)) - q16_type'(span);
   endfunction

   // slowly moving measured position, as from a real plant
   function automatic logic [RAW_W-1:0] wander();
      walk_pos += $urandom_range(0, 2000) - 1000;
      if (walk_pos < 0) walk_pos = 0;
      if (walk_pos > RAW_MAX) walk_pos = RAW_MAX;
      return walk_pos[RAW_W-1:0];
   endfunction

   task automatic pick_tracking_gains();
      next_set[CSR_TARGET] = $urandom_range(0, 100 << 16);
      next_set[CSR_GAIN_PROP] = spread(20 << 16);
      next_set[CSR_GAIN_SPEED] = spread(2 << 16);
      next_set[CSR_GAIN_DIST] = spread(1 << 16);
      next_set[CSR_BETA_ONE] = $urandom_range(100 << 16, 600 << 16);
      next_set[CSR_BETA_TWO] = $urandom_range(1000 << 16, 30000 << 16);
      next_set[CSR_BETA_THREE] = $urandom_range(1000 << 16, 32000 << 16);
      next_set[CSR_PLANT_GAIN] = $urandom_range(1 << 16, 100 << 16);
   endtask

   // ---------------- tests ----------------

   task automatic test_reset_defaults();
      send_tick('0);
      send_tick(RAW_MAX[RAW_W-1:0]);
      send_tick(20'h55555);
      send_tick(20'haaaaa);
      drain_ticks();
   endtask

   task automatic test_register_extremes();
      for (int i = 0; i < NUM_CSR; i++) next_set[i] = q16_type'(Q_MAX);
      apply_settings();
      send_tick('0);
      send_tick(RAW_MAX[RAW_W-1:0]);
      send_tick('0);
      drain_ticks();
      for (int i = 0; i < NUM_CSR; i++) next_set[i] = q16_type'(Q_MIN);
      apply_settings();
      send_tick(RAW_MAX[RAW_W-1:0]);
      send_tick('0);
      send_tick(RAW_MAX[RAW_W-1:0]);
      drain_ticks();
      // zero gains with the old estimates kept: drive sits at the low limit
      for (int i = 0; i < NUM_CSR; i++) next_set[i] = '0;
      apply_settings();
      send_tick(20'd1);
      send_tick(20'd10000);
      drain_ticks();
      // big proportional gain drives u past the upper limit
      pick_tracking_gains();
      next_set[CSR_TARGET] = -(100 << 16);
      next_set[CSR_GAIN_PROP] = 1000 << 16;
      apply_settings();
      send_tick(20'd500000);
      send_tick(20'd500000);
      drain_ticks();
   endtask

   task automatic test_tracking_loop();
      for (int set = 0; set < 4; set++) begin
         pick_tracking_gains();
         apply_settings();
         walk_pos = $urandom_range(0, RAW_MAX);
         for (int k = 0; k < 250; k++) begin
            if ($urandom_range(0, 9) < 8) send_tick(wander());
            else send_tick(RAW_W'($urandom_range(0, RAW_MAX)));
         end
         drain_ticks();
      end
   endtask

   task automatic test_random_settings();
      for (int set = 0; set < 8; set++) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            case ($urandom_range(0, 2))
               0: next_set[i] = $urandom;
               1: next_set[i] = spread(1 << 20);
               default: next_set[i] = spread(1 << 24);
            endcase
         end
         apply_settings();
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 1)) send_tick(wander());
            else send_tick(RAW_W'($urandom_range(0, RAW_MAX)));
         end
         drain_ticks();
      end
   endtask

   task automatic test_rsp_backpressure();
      pick_tracking_gains();
      apply_settings();
      for (int rep = 0; rep < 2; rep++) begin
         long_holds_asked++;
         burst_left = 60;
         for (int k = 0; k < 100; k++) send_tick(wander());
      end
      drain_ticks();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_position_raw = '0;
      csr_write = 1'b0;
      csr_index = CSR_TARGET;
      csr_data = '0;
      for (int i = 0; i < NUM_CSR; i++) csr_shadow[i] = '0;
      csr_shadow[CSR_PLANT_GAIN] = PLANT_GAIN_RESET;
      est_pos = '0;
      est_speed = '0;
      est_dist = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      repeat (5) @(negedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_tracking_loop();
      test_random_settings();
      test_rsp_backpressure();

      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d control ticks (%0d checked) over %0d register settings,",
               ticks_sent, ticks_checked, settings_loaded);
      $display("with %0d long rsp hold-offs; %0d field mismatches.",
               long_holds_asked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/epc_pkg.sv
src/epc_divider.sv
src/epc_sequencer.sv
src/epc_datapath.sv
src/eso_position_controller_top.sv
sim/tb_eso_position_controller_top.sv
